[hw/rtl/path_escape_encoder_macros.svh]
// Assertion macros for the path escape encoder checker.
`ifndef PATH_ESCAPE_ENCODER_MACROS_SVH
`define PATH_ESCAPE_ENCODER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PEE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pee_pkg.sv]
// Shared types, codes and character constants of the path escape encoder.
`timescale 1ns / 1ps
package pee_pkg;

  localparam int CpWidth           = 21;
  localparam int CharWidth         = 7;
  localparam int StepWidth         = 4;
  localparam int KindWidth         = 3;
  localparam int QueueDepthDefault = 4;

  // item classes
  localparam logic [KindWidth-1:0] KindPlain = 3'd0;
  localparam logic [KindWidth-1:0] KindSlash = 3'd1;
  localparam logic [KindWidth-1:0] KindDash  = 3'd2;
  localparam logic [KindWidth-1:0] KindHex   = 3'd3;
  localparam logic [KindWidth-1:0] KindEnd   = 3'd4;

  localparam logic [CpWidth-1:0] CpSlash     = 21'h00002F;
  localparam logic [CpWidth-1:0] CpBackslash = 21'h00005C;
  localparam logic [CpWidth-1:0] CpDash      = 21'h00002D;

  localparam logic [CharWidth-1:0] CharDash = 7'h2D;
  localparam logic [CharWidth-1:0] CharD    = 7'h64;
  localparam logic [CharWidth-1:0] CharLbr  = 7'h5B;
  localparam logic [CharWidth-1:0] CharRbr  = 7'h5D;
  localparam logic [CharWidth-1:0] CharDot  = 7'h2E;
  localparam logic [CharWidth-1:0] CharB    = 7'h62;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [CpWidth-1:0]   cp;
    logic [StepWidth-1:0] last_step;  // index of the final character of the run
  } cmd_t;

  function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] nib);
    logic [CharWidth-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

[hw/rtl/pee_front.sv]
// Front end: accepts input items, classifies them and counts hex digits.
`timescale 1ns / 1ps
module pee_front
  import pee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CpWidth-1:0] code_point,
  input  logic               end_of_path,
  input  logic               push,
  output logic               full,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  logic valid;
  logic valid_next;
  cmd_t cmd_next;
  logic accept;
  logic [StepWidth-1:0] digits;

  assign full      = valid && !cmd_ready;
  assign accept    = push && !full;
  assign cmd_valid = valid;

  always_comb begin
    // value is at least 0x80 here, so two digits minimum
    priority if (code_point[20]) begin
      digits = 4'd6;
    end else if (|code_point[19:16]) begin
      digits = 4'd5;
    end else if (|code_point[15:12]) begin
      digits = 4'd4;
    end else if (|code_point[11:8]) begin
      digits = 4'd3;
    end else begin
      digits = 4'd2;
    end
  end

  always_comb begin
    cmd_next.cp = code_point;
    priority if (end_of_path) begin
      cmd_next.kind      = KindEnd;
      cmd_next.last_step = 4'd2;
    end else if (code_point == CpSlash || code_point == CpBackslash) begin
      cmd_next.kind      = KindSlash;
      cmd_next.last_step = 4'd1;
    end else if (code_point == CpDash) begin
      cmd_next.kind      = KindDash;
      cmd_next.last_step = 4'd1;
    end else if (|code_point[CpWidth-1:7]) begin
      cmd_next.kind      = KindHex;
      cmd_next.last_step = digits + 4'd2;
    end else begin
      cmd_next.kind      = KindPlain;
      cmd_next.last_step = 4'd0;
    end
  end

  always_comb begin
    valid_next = valid;
    if (accept) begin
      valid_next = 1'b1;
    end else if (valid && cmd_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

[hw/rtl/pee_queue.sv]
// Short command queue between the front end and the character sequencer.
`timescale 1ns / 1ps
module pee_queue
  import pee_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
)(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  cmd_t          entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != CW'(Depth));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

[hw/rtl/pee_back.sv]
// Back end: emits the head command characters, one per cycle unless stalled.
`timescale 1ns / 1ps
module pee_back
  import pee_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  cmd_t                 cmd,
  output logic [CharWidth-1:0] out_char,
  output logic                 run_last,
  output logic                 empty,
  input  logic                 pop
);

  logic                 out_valid;
  logic [StepWidth-1:0] step;
  logic                 load;
  logic                 last;
  logic [CharWidth-1:0] char_next;
  logic [StepWidth-1:0] nib_pos;
  logic [23:0]          cp_ext;
  logic [3:0]           nib;

  assign empty  = !out_valid;
  assign load   = cmd_valid && (!out_valid || pop);
  assign last   = (step == cmd.last_step);
  assign cmd_pop = load && last;

  // digit index counted from the least significant nibble
  assign nib_pos = cmd.last_step - 4'd1 - step;
  assign cp_ext  = {3'b000, cmd.cp};

  always_comb begin
    unique case (nib_pos[2:0])
      3'd0:    nib = cp_ext[3:0];
      3'd1:    nib = cp_ext[7:4];
      3'd2:    nib = cp_ext[11:8];
      3'd3:    nib = cp_ext[15:12];
      3'd4:    nib = cp_ext[19:16];
      3'd5:    nib = cp_ext[23:20];
      default: nib = 4'h0;
    endcase
  end

  always_comb begin
    unique case (cmd.kind)
      KindPlain: char_next = cmd.cp[CharWidth-1:0];
      KindSlash: char_next = (step == 4'd0) ? CharDash : CharD;
      KindDash:  char_next = CharDash;
      KindHex: begin
        priority if (step == 4'd0) begin
          char_next = CharDash;
        end else if (step == 4'd1) begin
          char_next = CharLbr;
        end else if (last) begin
          char_next = CharRbr;
        end else begin
          char_next = hex_char(nib);
        end
      end
      KindEnd: begin
        priority if (step == 4'd0) begin
          char_next = CharDot;
        end else if (step == 4'd1) begin
          char_next = CharD;
        end else begin
          char_next = CharB;
        end
      end
      default:   char_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last ? '0 : step + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      run_last <= last;
    end
  end

endmodule

[hw/rtl/path_escape_encoder.sv]
// An item passes through the front register, the command queue and the output
// register before its run appears on the ports. Throughput: one character per
// cycle while pop is given; an item yields 1 to 9 characters, and the character
// sequencer on the queue head sets this rate. A command queue decouples input and
// output, so push continues while results wait, until it fills. Reset clears the
// front valid flag, queue pointers and the sequencer; empty is high, full is low.
`timescale 1ns / 1ps
module path_escape_encoder
  import pee_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CpWidth-1:0]   code_point,
  input  logic                 end_of_path,
  input  logic                 push,
  output logic                 full,
  output logic [CharWidth-1:0] out_char,
  output logic                 run_last,
  output logic                 empty,
  input  logic                 pop
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic head_valid;
  logic head_pop;
  cmd_t head_cmd;

  pee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_point (code_point),
    .end_of_path(end_of_path),
    .push       (push),
    .full       (full),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  pee_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(front_valid),
    .wr_ready(front_ready),
    .wr_data (front_cmd),
    .rd_valid(head_valid),
    .rd_pop  (head_pop),
    .rd_data (head_cmd)
  );

  pee_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd_pop  (head_pop),
    .cmd      (head_cmd),
    .out_char (out_char),
    .run_last (run_last),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[hw/rtl/pee_checker.sv]
// Port-level checker for the path escape encoder, bound to the top level.
`timescale 1ns / 1ps
`include "path_escape_encoder_macros.svh"
module pee_checker
  import pee_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic [CharWidth-1:0] out_char,
  input logic                 run_last,
  input logic                 empty,
  input logic                 pop
);

  `PEE_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty, "results present after reset")
  `PEE_ASSERT(a_hold_on_stall, (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(run_last)), "stalled item changed")
  `PEE_ASSERT(a_run_unbroken, (!empty && pop && !run_last) |=> !empty, "gap inside a character run")
  // a plain '[' ends its own run; an escape '[' is always followed by a digit
  `PEE_ASSERT(a_bracket_then_digit, (!empty && pop && out_char == CharLbr && !run_last) |=> (!empty && out_char != CharRbr), "escape closed without digits")

endmodule

bind path_escape_encoder pee_checker u_pee_checker (
  .clk     (clk),
  .rst     (rst),
  .out_char(out_char),
  .run_last(run_last),
  .empty   (empty),
  .pop     (pop)
);

[verif/path_escape_encoder_test.sv]
// Self-checking testbench for the path escape encoder.
`timescale 1ns / 1ps
module path_escape_encoder_test;
  import pee_pkg::*;

  localparam int                 CycleLimit  = 300000;
  localparam int                 DrainCycles = 20;
  localparam logic [CpWidth-1:0] EscapeFloor = 21'h000080;
  localparam logic [CpWidth-1:0] CpMax       = 21'h1FFFFF;
  localparam logic [CpWidth-1:0] CpUnicodeMax = 21'h10FFFF;

  // receiver stall modes
  localparam int PopAlways = 0;
  localparam int PopHalf   = 1;
  localparam int PopRare   = 2;

  typedef struct {
    logic [CharWidth-1:0] ch;
    logic                 is_last;
  } name_char_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [CpWidth-1:0]   code_point = '0;
  logic                 end_of_path = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [CharWidth-1:0] out_char;
  logic                 run_last;
  logic                 empty;
  logic                 pop = 1'b0;

  name_char_t pending_chars[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         stall_mode = PopAlways;
  int         stall_left = 0;

  path_escape_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .code_point  (code_point),
    .end_of_path (end_of_path),
    .push        (push),
    .full        (full),
    .out_char    (out_char),
    .run_last    (run_last),
    .empty       (empty),
    .pop         (pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_char(input logic [CharWidth-1:0] ch, input logic is_last);
    name_char_t c;
    c.ch = ch;
    c.is_last = is_last;
    pending_chars = {pending_chars, c};
  endfunction

  // expected character run for one accepted item
  function automatic void encode_code_point(input logic [CpWidth-1:0] cp, input logic eop);
    int          ndig;
    logic [3:0]  nib;
    logic [23:0] cp_ext;
    cp_ext = {3'b000, cp};
    if (eop) begin
      add_char(CharDot, 1'b0);
      add_char(CharD, 1'b0);
      add_char(CharB, 1'b1);
    end else if (cp == CpSlash || cp == CpBackslash) begin
      add_char(CharDash, 1'b0);
      add_char(CharD, 1'b1);
    end else if (cp == CpDash) begin
      add_char(CharDash, 1'b0);
      add_char(CharDash, 1'b1);
    end else if (cp >= EscapeFloor) begin
      ndig = 6;
      while (ndig > 1 && cp_ext[4*(ndig-1) +: 4] == 4'd0) ndig--;
      add_char(CharDash, 1'b0);
      add_char(CharLbr, 1'b0);
      for (int i = ndig - 1; i >= 0; i--) begin
        nib = cp_ext[4*i +: 4];
        add_char((nib > 4'd9) ? 7'h61 + {3'b000, nib} - 7'd10 : 7'h30 + {3'b000, nib}, 1'b0);
      end
      add_char(CharRbr, 1'b1);
    end else begin
      add_char(cp[CharWidth-1:0], 1'b1);
    end
  endfunction

  // drive one item and hold it until taken; the sender runs in bursts
  task automatic send_code_point(input logic [CpWidth-1:0] cp, input logic eop);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    code_point  <= cp;
    end_of_path <= eop;
    push        <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_code_point(cp, eop);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic test_plain_chars();
    send_code_point(21'h000000, 1'b0);
    send_code_point(21'h00007F, 1'b0);
    send_code_point(21'h000061, 1'b0);
    send_code_point(21'h00002E, 1'b0);
  endtask

  task automatic test_separators();
    send_code_point(CpSlash, 1'b0);
    send_code_point(CpBackslash, 1'b0);
    send_code_point(CpDash, 1'b0);
  endtask

  task automatic test_escapes();
    send_code_point(EscapeFloor, 1'b0);
    send_code_point(21'h0000FF, 1'b0);
    send_code_point(21'h000100, 1'b0);
    send_code_point(21'h00FFFF, 1'b0);
    send_code_point(21'h010000, 1'b0);
    send_code_point(CpUnicodeMax, 1'b0);
    // beyond the Unicode range: still escaped, six digits
    send_code_point(21'h110000, 1'b0);
    send_code_point(CpMax, 1'b0);
  endtask

  task automatic test_end_items();
    // code point is don't-care on an end item
    send_code_point(21'h000000, 1'b1);
    send_code_point(CpMax, 1'b1);
    send_code_point(CpSlash, 1'b1);
  endtask

  // well-formed paths: mostly text, some separators and escapes, then an end item
  task automatic test_random_paths(input int n_items);
    int                 sent;
    int                 len;
    int                 pick;
    int                 ndig;
    logic [CpWidth-1:0] cp;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 15);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          cp = CpWidth'($urandom_range(0, 127));
        end else if (pick < 70) begin
          cp = ($urandom_range(0, 1) != 0) ? CpSlash : CpBackslash;
        end else if (pick < 80) begin
          cp = CpDash;
        end else begin
          ndig = $urandom_range(2, 6);
          cp = CpWidth'($urandom_range(1 << (4 * (ndig - 1)), (1 << (4 * ndig)) - 1));
          if (cp < EscapeFloor) cp = EscapeFloor;
          if (ndig == 6) cp = cp & CpMax;
          if (cp < EscapeFloor) cp = CpUnicodeMax;
        end
        send_code_point(cp, 1'b0);
        sent++;
      end
      send_code_point(CpWidth'($urandom_range(0, CpMax)), 1'b1);
      sent++;
    end
  endtask

  task automatic test_noise(input int n_items);
    for (int k = 0; k < n_items; k++) begin
      send_code_point(CpWidth'($urandom_range(0, CpMax)), ($urandom_range(0, 9) == 0));
    end
  endtask

  // receiver stall pattern, switching between random stall modes
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(PopAlways, PopRare);
        stall_left = $urandom_range(8, 40);
      end
      stall_left--;
      case (stall_mode)
        PopAlways: pop <= 1'b1;
        PopHalf:   pop <= ($urandom_range(0, 1) != 0);
        default:   pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    name_char_t exp_c;
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected item, out_char %h run_last %b", $time, out_char, run_last);
        mismatch_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char expected %h got %h", $time, exp_c.ch, out_char);
          mismatch_count++;
        end
        if (run_last !== exp_c.is_last) begin
          $display("%0t: run_last expected %b got %b", $time, exp_c.is_last, run_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plain_chars();
    test_separators();
    test_escapes();
    test_end_items();
    test_random_paths(170);
    test_noise(30);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
